// ===== hdl/mfbb_pkg.sv =====
`default_nettype none
package mfbb_pkg;

   localparam int IDX_W = 17;
   localparam logic [IDX_W:0] IDX_LIMIT = 18'd65536;

   localparam logic [2:0] CMD_CLEAR     = 3'd0;
   localparam logic [2:0] CMD_PIXEL     = 3'd1;
   localparam logic [2:0] CMD_IMG_START = 3'd2;
   localparam logic [2:0] CMD_IMG_BYTE  = 3'd3;
   localparam logic [2:0] CMD_READ      = 3'd4;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BOUNDS   = 2'd1;
   localparam logic [1:0] STAT_DROPPED  = 2'd2;
   localparam logic [1:0] STAT_NO_IMAGE = 2'd3;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_MOD0,
      S_MOD1,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] img_width;
      logic [7:0] img_height;
      logic       color;
      logic [7:0] bitmap_byte;
      logic [9:0] read_address;
   } req_type;

   typedef struct packed {
      logic       image_active;
      logic [1:0] status;
      logic [7:0] read_data;
   } rsp_type;

   function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > IDX_LIMIT) ? IDX_LIMIT[IDX_W-1:0] : s[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== hdl/mfbb_store.sv =====
`default_nettype none
module mfbb_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/mfbb_engine.sv =====
`default_nettype none
module mfbb_engine #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS    = 64,
   localparam int BufBytes = SCREEN_ROWS * ((SCREEN_COLUMNS + 7) / 8),
   localparam int AddrW    = $clog2(BufBytes)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire mfbb_pkg::req_type req,
   output logic                  req_ready,
   input  wire logic             rsp_free,
   output logic                  rsp_load,
   output mfbb_pkg::rsp_type     rsp,
   output logic                  mem_rd_en,
   output logic [AddrW-1:0]      mem_rd_addr,
   input  wire logic [7:0]       mem_rd_data,
   output logic                  mem_wr_en,
   output logic [AddrW-1:0]      mem_wr_addr,
   output logic [7:0]            mem_wr_data
);

   localparam int IW = mfbb_pkg::IDX_W;

   mfbb_pkg::state_type state_ff, state_in;
   mfbb_pkg::req_type   item_ff, item_in;

   logic [AddrW-1:0] clr_cnt_ff, clr_cnt_in;
   logic             clr_cmd_ff, clr_cmd_in;
   logic [IW-1:0]    cursor_ff, cursor_in;
   logic [IW-1:0]    row_start_ff, row_start_in;
   logic [7:0]       cols_left_ff, cols_left_in;
   logic [7:0]       width_ff, width_in;
   logic [7:0]       rows_left_ff, rows_left_in;
   logic             busy_ff, busy_in;

   logic [1:0]       status_ff, status_in;
   logic [15:0]      wmask_ff, wmask_in;
   logic [15:0]      wdata_ff, wdata_in;
   logic             do_b0_ff, do_b0_in;
   logic             do_b1_ff, do_b1_in;
   logic [AddrW-1:0] addr0_ff, addr0_in;
   logic [7:0]       data_ff, data_in;

   logic [IW-1:0]    pix_idx;
   logic             in_bounds;
   logic [3:0]       n_bits;
   logic [IW-1:0]    base;
   logic [7:0]       bits8;
   logic [7:0]       nmask8;
   logic [15:0]      wmask;
   logic [15:0]      wdata;
   logic [13:0]      byte0;
   logic             byte0_ok;
   logic             byte1_ok;
   logic             lo_any;
   logic             hi_any;
   logic             read_ok;
   logic [IW-1:0]    cur_step;
   logic [7:0]       cols_rem;
   logic [IW-1:0]    row_next;
   logic [7:0]       rows_rem;
   logic             clr_last;

   // index and mask arithmetic
   always_comb begin
      pix_idx   = IW'(item_ff.x_pos) + IW'(item_ff.y_pos) * IW'(SCREEN_COLUMNS);
      in_bounds = (9'(item_ff.x_pos) < 9'(SCREEN_COLUMNS))
               && (9'(item_ff.y_pos) < 9'(SCREEN_ROWS));
      if (item_ff.command == mfbb_pkg::CMD_PIXEL) begin
         n_bits = 4'd1;
         base   = pix_idx;
         bits8  = {7'd0, item_ff.color};
      end else begin
         n_bits = (cols_left_ff < 8'd8) ? cols_left_ff[3:0] : 4'd8;
         base   = cursor_ff;
         bits8  = item_ff.bitmap_byte;
      end
      nmask8   = 8'((9'd1 << n_bits) - 9'd1);
      wmask    = {8'd0, nmask8} << base[2:0];
      wdata    = {8'd0, bits8 & nmask8} << base[2:0];
      byte0    = base[IW-1:3];
      byte0_ok = 15'(byte0) < 15'(BufBytes);
      byte1_ok = (15'(byte0) + 15'd1) < 15'(BufBytes);
      lo_any   = |wmask[7:0];
      hi_any   = |wmask[15:8];
      read_ok  = 15'(item_ff.read_address) < 15'(BufBytes);
      cur_step = mfbb_pkg::sat_add(cursor_ff, IW'(n_bits));
      cols_rem = cols_left_ff - 8'(n_bits);
      row_next = mfbb_pkg::sat_add(row_start_ff, IW'(SCREEN_COLUMNS));
      rows_rem = rows_left_ff - 8'd1;
      clr_last = clr_cnt_ff == AddrW'(BufBytes - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfbb_pkg::S_CLEAR: begin
            if (clr_last) begin
               state_in = clr_cmd_ff ? mfbb_pkg::S_DONE : mfbb_pkg::S_IDLE;
            end
         end
         mfbb_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = mfbb_pkg::S_EXEC;
            end
         end
         mfbb_pkg::S_EXEC: begin
            state_in = (item_ff.command == mfbb_pkg::CMD_CLEAR) ? mfbb_pkg::S_CLEAR
                                                                 : mfbb_pkg::S_MOD0;
         end
         mfbb_pkg::S_MOD0: begin
            state_in = do_b1_ff ? mfbb_pkg::S_MOD1 : mfbb_pkg::S_DONE;
         end
         mfbb_pkg::S_MOD1: begin
            state_in = mfbb_pkg::S_DONE;
         end
         mfbb_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = mfbb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mfbb_pkg::S_IDLE;
         end
      endcase
   end

   // memory and handshake outputs
   always_comb begin
      req_ready   = state_ff == mfbb_pkg::S_IDLE;
      rsp_load    = (state_ff == mfbb_pkg::S_DONE) && rsp_free;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr0_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr0_ff;
      mem_wr_data = (mem_rd_data & ~wmask_ff[7:0]) | wdata_ff[7:0];
      case (state_ff)
         mfbb_pkg::S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = 8'd0;
         end
         mfbb_pkg::S_EXEC: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = (item_ff.command == mfbb_pkg::CMD_READ)
                        ? AddrW'(item_ff.read_address) : AddrW'(byte0);
         end
         mfbb_pkg::S_MOD0: begin
            mem_wr_en   = do_b0_ff;
            mem_rd_en   = do_b1_ff;
            mem_rd_addr = addr0_ff + AddrW'(1);
         end
         mfbb_pkg::S_MOD1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = addr0_ff + AddrW'(1);
            mem_wr_data = (mem_rd_data & ~wmask_ff[15:8]) | wdata_ff[15:8];
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
      rsp.image_active = busy_ff;
      rsp.status       = status_ff;
      rsp.read_data    = data_ff;
   end

   // datapath and image state updates
   always_comb begin
      item_in      = item_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_cmd_in   = clr_cmd_ff;
      cursor_in    = cursor_ff;
      row_start_in = row_start_ff;
      cols_left_in = cols_left_ff;
      width_in     = width_ff;
      rows_left_in = rows_left_ff;
      busy_in      = busy_ff;
      status_in    = status_ff;
      wmask_in     = wmask_ff;
      wdata_in     = wdata_ff;
      do_b0_in     = do_b0_ff;
      do_b1_in     = do_b1_ff;
      addr0_in     = addr0_ff;
      data_in      = data_ff;
      case (state_ff)
         mfbb_pkg::S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AddrW'(1);
         end
         mfbb_pkg::S_IDLE: begin
            if (req_valid) begin
               item_in = req;
            end
         end
         mfbb_pkg::S_EXEC: begin
            status_in  = mfbb_pkg::STAT_OK;
            data_in    = 8'd0;
            do_b0_in   = 1'b0;
            do_b1_in   = 1'b0;
            wmask_in   = wmask;
            wdata_in   = wdata;
            addr0_in   = AddrW'(byte0);
            clr_cnt_in = '0;
            clr_cmd_in = 1'b0;
            case (item_ff.command)
               mfbb_pkg::CMD_CLEAR: begin
                  clr_cmd_in = 1'b1;
               end
               mfbb_pkg::CMD_PIXEL: begin
                  if (!in_bounds) begin
                     status_in = mfbb_pkg::STAT_BOUNDS;
                  end else if (!byte0_ok) begin
                     status_in = mfbb_pkg::STAT_DROPPED;
                  end else begin
                     do_b0_in = 1'b1;
                  end
               end
               mfbb_pkg::CMD_IMG_START: begin
                  if (!in_bounds) begin
                     status_in = mfbb_pkg::STAT_BOUNDS;
                     busy_in   = 1'b0;
                  end else if (item_ff.img_width == 8'd0 || item_ff.img_height == 8'd0) begin
                     busy_in = 1'b0;
                  end else begin
                     cursor_in    = pix_idx;
                     row_start_in = pix_idx;
                     cols_left_in = item_ff.img_width;
                     width_in     = item_ff.img_width;
                     rows_left_in = item_ff.img_height;
                     busy_in      = 1'b1;
                  end
               end
               mfbb_pkg::CMD_IMG_BYTE: begin
                  if (!busy_ff) begin
                     status_in = mfbb_pkg::STAT_NO_IMAGE;
                  end else begin
                     do_b0_in = lo_any && byte0_ok;
                     do_b1_in = hi_any && byte1_ok;
                     if ((lo_any && !byte0_ok) || (hi_any && !byte1_ok)) begin
                        status_in = mfbb_pkg::STAT_DROPPED;
                     end
                     if (cols_rem == 8'd0) begin
                        rows_left_in = rows_rem;
                        row_start_in = row_next;
                        cursor_in    = row_next;
                        cols_left_in = width_ff;
                        busy_in      = rows_rem != 8'd0;
                     end else begin
                        cursor_in    = cur_step;
                        cols_left_in = cols_rem;
                     end
                  end
               end
               mfbb_pkg::CMD_READ: begin
                  if (!read_ok) begin
                     status_in = mfbb_pkg::STAT_BOUNDS;
                  end
               end
               default: begin
                  status_in = mfbb_pkg::STAT_OK;
               end
            endcase
         end
         mfbb_pkg::S_MOD0: begin
            if (item_ff.command == mfbb_pkg::CMD_READ && status_ff == mfbb_pkg::STAT_OK) begin
               data_in = mem_rd_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfbb_pkg::S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_cmd_ff   <= 1'b0;
         cursor_ff    <= '0;
         row_start_ff <= '0;
         cols_left_ff <= '0;
         width_ff     <= '0;
         rows_left_ff <= '0;
         busy_ff      <= 1'b0;
         do_b0_ff     <= 1'b0;
         do_b1_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_cmd_ff   <= clr_cmd_in;
         cursor_ff    <= cursor_in;
         row_start_ff <= row_start_in;
         cols_left_ff <= cols_left_in;
         width_ff     <= width_in;
         rows_left_ff <= rows_left_in;
         busy_ff      <= busy_in;
         do_b0_ff     <= do_b0_in;
         do_b1_ff     <= do_b1_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      status_ff <= status_in;
      wmask_ff  <= wmask_in;
      wdata_ff  <= wdata_in;
      addr0_ff  <= addr0_in;
      data_ff   <= data_in;
   end

endmodule
`default_nettype wire

// ===== hdl/mono_frame_buffer_blit_unit.sv =====
`default_nettype none
// one-bit-per-pixel frame buffer with clear, pixel, image blit and byte read commands
// req channel: one command item per handshake, command kind in req_tuser,
// operands in req_tdata; rsp channel: exactly one result item per command
// pixel (x, y) sits at linear index x + y*SCREEN_COLUMNS, lsb first in bytes;
// the buffer is SCREEN_ROWS*ceil(SCREEN_COLUMNS/8) bytes in one memory with
// a registered read port and one write port
// rsp_tvalid rises after the steps that follow the accepting edge: decode
// and read, modify and write the first byte, modify and write the second
// byte (only when an image byte writes two buffer bytes), load the result
// register once it is free; the next item is accepted after that load
// a clear command sweeps the memory one byte per cycle over all
// SCREEN_ROWS*ceil(SCREEN_COLUMNS/8) bytes before its result is loaded
// after reset the same sweep runs over all SCREEN_ROWS*ceil(SCREEN_COLUMNS/8)
// bytes with req_tready low; image state resets to idle
// results wait in an output register; the next item is accepted while a
// result waits, and its own result holds until rsp_tready frees the register
module mono_frame_buffer_blit_unit #(
   parameter int SCREEN_COLUMNS = 128,
   parameter int SCREEN_ROWS    = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // x_pos[7:0], y_pos[15:8], img_width[23:16], img_height[31:24], color[32],
   // bitmap_byte[40:33], read_address[50:41], zero[55:51]
   input  wire logic [55:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // read_data[7:0], status[9:8], image_active[10], zero[15:11]
   output logic [15:0]      rsp_tdata
);

   localparam int BufBytes = SCREEN_ROWS * ((SCREEN_COLUMNS + 7) / 8);
   localparam int AddrW    = $clog2(BufBytes);

   mfbb_pkg::req_type req;
   mfbb_pkg::rsp_type rsp;
   mfbb_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_free;
   logic              rsp_load;

   logic             mem_rd_en;
   logic [AddrW-1:0] mem_rd_addr;
   logic [7:0]       mem_rd_data;
   logic             mem_wr_en;
   logic [AddrW-1:0] mem_wr_addr;
   logic [7:0]       mem_wr_data;

   always_comb begin
      req.command      = req_tuser;
      req.x_pos        = req_tdata[7:0];
      req.y_pos        = req_tdata[15:8];
      req.img_width    = req_tdata[23:16];
      req.img_height   = req_tdata[31:24];
      req.color        = req_tdata[32];
      req.bitmap_byte  = req_tdata[40:33];
      req.read_address = req_tdata[50:41];
   end

   mfbb_engine #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS   (SCREEN_ROWS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req        (req),
      .req_ready  (req_tready),
      .rsp_free   (rsp_free),
      .rsp_load   (rsp_load),
      .rsp        (rsp),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data)
   );

   mfbb_store #(
      .DEPTH (BufBytes),
      .ADDR_W(AddrW)
   ) u_store (
      .clock  (clock),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data)
   );

   // output register
   always_comb begin
      rsp_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule
`default_nettype wire

// ===== tb/sv/mono_frame_buffer_blit_unit_test.sv =====
module mono_frame_buffer_blit_unit_test;
   import mfbb_pkg::*;

   localparam int SCREEN_COLUMNS = 128;
   localparam int SCREEN_ROWS    = 64;
   localparam int BUF_BYTES      = SCREEN_ROWS * ((SCREEN_COLUMNS + 7) / 8);
   localparam int RANDOM_ITEMS   = 2000;
   localparam int RUN_LIMIT      = 1000000;

   localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

   typedef enum {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_RHYTHM} ready_style_t;

   class frame_buffer_shadow;
      logic [7:0]  pixels [BUF_BYTES];
      int unsigned cursor;
      int unsigned row_base;
      int unsigned cols_left;
      logic [7:0]  row_width;
      logic [7:0]  rows_left;
      bit          busy;
      rsp_type     pending_rsps [$];
      int unsigned error_count;

      function new();
         wipe();
         cursor      = 0;
         row_base    = 0;
         cols_left   = 0;
         row_width   = '0;
         rows_left   = '0;
         busy        = 1'b0;
         error_count = 0;
      endfunction

      function void wipe();
         foreach (pixels[i]) pixels[i] = '0;
      endfunction

      function int unsigned index_add(int unsigned a, int unsigned b);
         return (a + b > IDX_LIMIT) ? int'(IDX_LIMIT) : a + b;
      endfunction

      function bit put_pixel(int unsigned idx, logic value);
         if (idx >= BUF_BYTES * 8) return 1'b0;
         pixels[idx / 8][idx % 8] = value;
         return 1'b1;
      endfunction

      function void note_command(req_type r);
         rsp_type     res;
         int unsigned n;
         res = '0;
         case (r.command)
            CMD_CLEAR: wipe();
            CMD_PIXEL: begin
               if (r.x_pos >= SCREEN_COLUMNS || r.y_pos >= SCREEN_ROWS)
                  res.status = STAT_BOUNDS;
               else if (!put_pixel(int'(r.x_pos) + int'(r.y_pos) * SCREEN_COLUMNS, r.color))
                  res.status = STAT_DROPPED;
            end
            CMD_IMG_START: begin
               if (r.x_pos >= SCREEN_COLUMNS || r.y_pos >= SCREEN_ROWS) begin
                  res.status = STAT_BOUNDS;
                  busy = 1'b0;
               end else if (r.img_width == 0 || r.img_height == 0) begin
                  busy = 1'b0;
               end else begin
                  cursor    = int'(r.x_pos) + int'(r.y_pos) * SCREEN_COLUMNS;
                  row_base  = cursor;
                  cols_left = r.img_width;
                  row_width = r.img_width;
                  rows_left = r.img_height;
                  busy      = 1'b1;
               end
            end
            CMD_IMG_BYTE: begin
               if (!busy) begin
                  res.status = STAT_NO_IMAGE;
               end else begin
                  n = (cols_left < 8) ? cols_left : 8;
                  for (int i = 0; i < n; i++)
                     if (!put_pixel(index_add(cursor, i), r.bitmap_byte[i]))
                        res.status = STAT_DROPPED;
                  cursor = index_add(cursor, n);
                  cols_left -= n;
                  if (cols_left == 0) begin
                     rows_left = rows_left - 8'd1;
                     row_base  = index_add(row_base, SCREEN_COLUMNS);
                     cursor    = row_base;
                     cols_left = row_width;
                     if (rows_left == 0) busy = 1'b0;
                  end
               end
            end
            CMD_READ: begin
               if (r.read_address < BUF_BYTES) res.read_data = pixels[r.read_address];
               else res.status = STAT_BOUNDS;
            end
            default: ;
         endcase
         res.image_active = busy;
         pending_rsps.push_back(res);
      endfunction

      function void check_result(logic [15:0] word);
         rsp_type got;
         rsp_type want;
         got = word[10:0];
         if (pending_rsps.size() == 0) begin
            $error("rsp item with nothing pending: %h", word);
            error_count++;
            return;
         end
         want = pending_rsps.pop_front();
         if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0d, got %0d", want.read_data, got.read_data);
            error_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.image_active !== want.image_active) begin
            $error("image_active: expected %0d, got %0d", want.image_active,
                   got.image_active);
            error_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   frame_buffer_shadow board;
   int unsigned        items_sent = 0;
   int unsigned        burst_left = 0;
   int unsigned        focus_byte = 0;
   ready_style_t       ready_style = READY_ALWAYS;
   int unsigned        style_left = 0;

   mono_frame_buffer_blit_unit #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS(SCREEN_ROWS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("mono_frame_buffer_blit_unit_test: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      if (style_left == 0) begin
         ready_style = ready_style_t'($urandom_range(0, 3));
         style_left  = $urandom_range(20, 200);
      end else begin
         style_left--;
      end
      case (ready_style)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_RARELY: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= (style_left % 8 == 0);
      endcase
   end

   function automatic req_type random_fields(logic [2:0] cmd);
      req_type r;
      r.command      = cmd;
      r.x_pos        = $urandom;
      r.y_pos        = $urandom;
      r.img_width    = $urandom;
      r.img_height   = $urandom;
      r.color        = $urandom;
      r.bitmap_byte  = $urandom;
      r.read_address = $urandom;
      return r;
   endfunction

   task automatic send_item(req_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.command;
      req_tdata  <= {5'b0, it.read_address, it.bitmap_byte, it.color, it.img_height,
                     it.img_width, it.y_pos, it.x_pos};
      do @(posedge clock); while (!req_tready);
      board.note_command(it);
      items_sent++;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_command(logic [2:0] cmd);
      send_item(random_fields(cmd));
   endtask

   task automatic send_pixel(int unsigned x, int unsigned y, int unsigned c);
      req_type it;
      it       = random_fields(CMD_PIXEL);
      it.x_pos = x;
      it.y_pos = y;
      it.color = c;
      send_item(it);
   endtask

   task automatic send_start(int unsigned x, int unsigned y, int unsigned w, int unsigned h);
      req_type it;
      it            = random_fields(CMD_IMG_START);
      it.x_pos      = x;
      it.y_pos      = y;
      it.img_width  = w;
      it.img_height = h;
      send_item(it);
   endtask

   task automatic send_bits(int unsigned b);
      req_type it;
      it             = random_fields(CMD_IMG_BYTE);
      it.bitmap_byte = b;
      send_item(it);
   endtask

   task automatic send_read(int unsigned a);
      req_type it;
      it              = random_fields(CMD_READ);
      it.read_address = a;
      send_item(it);
   endtask

   task automatic wait_for_results();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (board.pending_rsps.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned pick;
      int unsigned shape;
      int unsigned x;
      int unsigned y;
      int unsigned w;
      int unsigned h;
      int unsigned nbytes;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_read(0);
      send_pixel(0, 0, 1);
      send_pixel(SCREEN_COLUMNS - 1, SCREEN_ROWS - 1, 1);
      send_pixel(SCREEN_COLUMNS, 0, 1);
      send_pixel(0, SCREEN_ROWS, 1);
      send_read(0);
      send_read(BUF_BYTES - 1);
      send_pixel(SCREEN_COLUMNS - 1, SCREEN_ROWS - 1, 0);
      // image byte with no image running
      send_bits(8'hFF);
      send_start(0, 0, 0, 5);
      send_start(3, 3, 7, 0);
      // rows run over the right edge, bytes straddle buffer bytes
      send_start(SCREEN_COLUMNS - 2, 0, 10, 2);
      send_bits(8'hFF);
      send_bits(8'h03);
      send_bits(8'hA5);
      send_bits(8'h02);
      send_read(15);
      send_read(16);
      // lower rows fall past the buffer end
      send_start(5, SCREEN_ROWS - 1, 16, 3);
      send_bits(8'hFF);
      send_bits(8'h0F);
      send_bits(8'h55);
      // rejected start ends the running image
      send_start(255, 255, 8, 8);
      send_bits(8'h81);
      send_command(CMD_LAST_UNUSED);
      send_command(CMD_CLEAR);
      send_read(0);
      wait_for_results();

      while (items_sent < RANDOM_ITEMS + 25) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, SCREEN_COLUMNS - 1);
            y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(0, SCREEN_ROWS - 1);
            shape = $urandom_range(0, 99);
            if (shape < 85) begin
               w = $urandom_range(1, 24);
               h = $urandom_range(1, 6);
            end else if (shape < 92) begin
               w = $urandom_range(0, 255);
               h = $urandom_range(1, 2);
            end else if (shape < 95) begin
               w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
               h = (w == 0) ? $urandom_range(0, 255) : 0;
            end else begin
               w = $urandom_range(1, 8);
               h = $urandom_range(100, 255);
            end
            send_start(x, y, w, h);
            focus_byte = ((x + y * SCREEN_COLUMNS) / 8) % BUF_BYTES;
            if (x < SCREEN_COLUMNS && y < SCREEN_ROWS && w != 0 && h != 0)
               nbytes = ((w + 7) / 8) * h;
            else
               nbytes = $urandom_range(0, 2);
            // abandoned image
            if ($urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes);
            for (int k = 0; k < nbytes; k++) begin
               if ($urandom_range(0, 6) == 0) begin
                  if ($urandom_range(0, 1))
                     send_read((focus_byte + $urandom_range(0, 47)) % BUF_BYTES);
                  else
                     send_pixel($urandom_range(0, SCREEN_COLUMNS - 1),
                                $urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, 1));
               end
               send_bits($urandom_range(0, 255));
            end
         end else if (pick < 72) begin
            if ($urandom_range(0, 3) == 0)
               send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 1));
            else
               send_pixel($urandom_range(0, SCREEN_COLUMNS - 1),
                          $urandom_range(0, SCREEN_ROWS - 1), $urandom_range(0, 1));
         end else if (pick < 92) begin
            if ($urandom_range(0, 1))
               send_read((focus_byte + $urandom_range(0, 47)) % BUF_BYTES);
            else
               send_read($urandom_range(0, 1023));
         end else if (pick < 95) begin
            send_bits($urandom_range(0, 255));
         end else if (pick < 97) begin
            send_command($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
         end else begin
            send_command(CMD_CLEAR);
         end
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (board.error_count == 0 && board.pending_rsps.size() == 0)
         $display("mono_frame_buffer_blit_unit_test: done, clean");
      else
         $display("mono_frame_buffer_blit_unit_test: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mfbb_pkg.sv
hdl/mfbb_store.sv
hdl/mfbb_engine.sv
hdl/mono_frame_buffer_blit_unit.sv
tb/sv/mono_frame_buffer_blit_unit_test.sv
